/* src/xbd_pkg.sv */
// Shared types and constants for the XTEA block decipher.
`default_nettype none
package xbd_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned ADDR_W    = 5;
    localparam int unsigned NUM_KEYS  = 4;

    // register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_ROUND_CONSTANT = 3'd0;
    localparam logic [2:0] REG_KEY_WORD_0     = 3'd1;
    localparam logic [2:0] REG_KEY_WORD_1     = 3'd2;
    localparam logic [2:0] REG_KEY_WORD_2     = 3'd3;
    localparam logic [2:0] REG_KEY_WORD_3     = 3'd4;

    localparam logic [WORD_W-1:0] DELTA_RESET = 32'h9E37_79B9;

    typedef struct packed {
        logic [WORD_W-1:0] cipher_left;
        logic [WORD_W-1:0] cipher_right;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] plain_left;
        logic [WORD_W-1:0] plain_right;
    } t_out_item;

    typedef struct packed {
        logic [WORD_W-1:0]                round_constant;
        logic [NUM_KEYS-1:0][WORD_W-1:0]  key_word;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] left;
        logic [WORD_W-1:0] right;
        logic [WORD_W-1:0] sum;
    } t_stage;

endpackage
`default_nettype wire

/* src/xtea_block_decipher.sv */
// XTEA-style 64-bit block decipher: top level with input register and round pipeline.
// Pipeline: 2*ROUNDS+1 stages; o_out_valid rises when the accepted block reaches the last round's second stage.
// Throughput: one block per cycle; one register stage per half-round, plus an input stage.
// The whole pipeline advances together; it holds only while a finished result is stalled.
// Reset (synchronous, active low) empties every stage and loads the round constant
// with 0x9E3779B9 and all key words with zero.
`default_nettype none
module xtea_block_decipher #(
    parameter int unsigned ROUNDS = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // input channel
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire xbd_pkg::t_in_item           i_in_item,
    // output channel
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output xbd_pkg::t_out_item               o_out_item,
    // configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [xbd_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [xbd_pkg::WORD_W-1:0]  pwdata,
    output logic      [xbd_pkg::WORD_W-1:0]  prdata,
    output logic                             pready
);

    // The sum starts at -ROUNDS * delta, folded into one multiply by the
    // constant (2^32 - ROUNDS).
    localparam logic [xbd_pkg::WORD_W-1:0] NEG_ROUNDS =
        xbd_pkg::WORD_W'(0) - xbd_pkg::WORD_W'(ROUNDS);

    xbd_pkg::t_cfg   w_cfg;
    xbd_pkg::t_stage w_stage [0:ROUNDS];
    xbd_pkg::t_stage r_in;
    logic            w_adv;
    logic [xbd_pkg::WORD_W-1:0] w_sum_init;

    // Configuration registers. Writes must land only while the pipeline is empty (the user's
    // duty; the block itself does not enforce it), so that every stage may read them directly.
    xbd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Advance every stage unless the output holds a result that is stalled.
    // A bubble in the output stage lets the pipeline move even under stall.
    assign w_adv      = !(o_out_valid && i_out_stall);
    assign o_in_stall = !w_adv;

    assign w_sum_init = w_cfg.round_constant * NEG_ROUNDS;

    // Input stage: capture the halves and the starting sum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else if (w_adv) begin
            r_in.valid <= i_in_valid;
            r_in.left  <= i_in_item.cipher_left;
            r_in.right <= i_in_item.cipher_right;
            r_in.sum   <= w_sum_init;
        end
    end

    assign w_stage[0] = r_in;

    // One round per instance, two register stages each.
    for (genvar g = 0; g < ROUNDS; g++) begin : g_round
        xbd_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_cfg   (w_cfg),
            .i_stage (w_stage[g]),
            .o_stage (w_stage[g+1])
        );
    end

    // The last round's second stage doubles as the output register.
    assign o_out_valid            = w_stage[ROUNDS].valid;
    assign o_out_item.plain_left  = w_stage[ROUNDS].left;
    assign o_out_item.plain_right = w_stage[ROUNDS].right;

`ifndef SYNTHESIS
    // An accepted transaction must occupy the input stage on the next edge.
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_in.valid)
        else $error("accepted transaction missing from input stage");

    // The input side may only be stalled by a stalled, valid result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a stalled result");

    // While the pipeline holds, the input stage keeps its item.
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_stall && r_in.valid) |=> (r_in.valid && $stable(r_in.sum)))
        else $error("input stage changed during a hold");

    // Reset empties the output stage.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
`endif

endmodule
`default_nettype wire

/* src/xbd_cfg.sv */
// APB-style configuration registers: round constant and four key words.
`default_nettype none
module xbd_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [xbd_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [xbd_pkg::WORD_W-1:0]  pwdata,
    output logic      [xbd_pkg::WORD_W-1:0]  prdata,
    output logic                             pready,
    output xbd_pkg::t_cfg                    o_cfg
);

    logic [xbd_pkg::WORD_W-1:0] r_round_constant;
    logic [xbd_pkg::NUM_KEYS-1:0][xbd_pkg::WORD_W-1:0] r_key_word;
    logic [2:0] w_index;
    logic       w_write;

    assign w_index = paddr[4:2];
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round_constant <= xbd_pkg::DELTA_RESET;
            r_key_word       <= '0;
        end else if (w_write) begin
            case (w_index)
                xbd_pkg::REG_ROUND_CONSTANT: r_round_constant <= pwdata;
                xbd_pkg::REG_KEY_WORD_0:     r_key_word[0]    <= pwdata;
                xbd_pkg::REG_KEY_WORD_1:     r_key_word[1]    <= pwdata;
                xbd_pkg::REG_KEY_WORD_2:     r_key_word[2]    <= pwdata;
                xbd_pkg::REG_KEY_WORD_3:     r_key_word[3]    <= pwdata;
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    always_comb begin
        case (w_index)
            xbd_pkg::REG_ROUND_CONSTANT: prdata = r_round_constant;
            xbd_pkg::REG_KEY_WORD_0:     prdata = r_key_word[0];
            xbd_pkg::REG_KEY_WORD_1:     prdata = r_key_word[1];
            xbd_pkg::REG_KEY_WORD_2:     prdata = r_key_word[2];
            xbd_pkg::REG_KEY_WORD_3:     prdata = r_key_word[3];
            default:                     prdata = '0;
        endcase
    end

    assign o_cfg.round_constant = r_round_constant;
    assign o_cfg.key_word       = r_key_word;

endmodule
`default_nettype wire

/* src/xbd_round.sv */
// One decipher round as two register stages: right-half update, then left-half update.
`default_nettype none
module xbd_round (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_adv,
    input  wire xbd_pkg::t_cfg   i_cfg,
    input  wire xbd_pkg::t_stage i_stage,
    output xbd_pkg::t_stage      o_stage
);

    function automatic logic [xbd_pkg::WORD_W-1:0] mix_half(
        input logic [xbd_pkg::WORD_W-1:0] v
    );
        return v + ((v >> 5) ^ (v << 4));
    endfunction

    xbd_pkg::t_stage r_mid;
    xbd_pkg::t_stage r_out;
    logic [xbd_pkg::WORD_W-1:0] n_mid_right;
    logic [xbd_pkg::WORD_W-1:0] n_mid_sum;
    logic [xbd_pkg::WORD_W-1:0] n_out_left;

    // first half-update: key word from sum bits 12:11, then raise the sum
    assign n_mid_right = i_stage.right -
        ((i_cfg.key_word[i_stage.sum[12:11]] + i_stage.sum) ^ mix_half(i_stage.left));
    assign n_mid_sum   = i_stage.sum + i_cfg.round_constant;

    // second half-update: key word from bits 1:0 of the raised sum
    assign n_out_left  = r_mid.left -
        ((i_cfg.key_word[r_mid.sum[1:0]] + r_mid.sum) ^ mix_half(r_mid.right));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid.valid <= 1'b0;
            r_out.valid <= 1'b0;
        end else if (i_adv) begin
            r_mid.valid <= i_stage.valid;
            r_out.valid <= r_mid.valid;
            r_mid.left  <= i_stage.left;
            r_mid.right <= n_mid_right;
            r_mid.sum   <= n_mid_sum;
            r_out.left  <= n_out_left;
            r_out.right <= r_mid.right;
            r_out.sum   <= r_mid.sum;
        end
    end

    assign o_stage = r_out;

endmodule
`default_nettype wire

/* tb/xtea_block_decipher_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the XTEA block decipher: directed, random and backpressure traffic.
module xtea_block_decipher_tb;
    import xbd_pkg::*;

    localparam int unsigned ROUND_COUNT      = 32;
    localparam int unsigned CLK_PERIOD       = 10;
    localparam int unsigned RESET_CYCLES     = 9;
    localparam int unsigned MAX_IDLE         = 17;
    // one stage per half-round plus the input stage
    localparam int unsigned PIPE_LATENCY     = 2 * ROUND_COUNT + 1;
    localparam int unsigned TIMEOUT_CYCLES   = 400_000;
    localparam int unsigned HOLD_OFF_CYCLES  = 300;
    localparam int unsigned RANDOM_PHASES    = 6;
    localparam int unsigned BLOCKS_PER_PHASE = 120;
    localparam int unsigned BURST_BLOCKS     = 130;
    // indexes past the register map; writes there must leave the map untouched
    localparam logic [2:0]  REG_FIRST_UNMAPPED = 3'd5;

    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    t_in_item          i_in_item   = '0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out_item         o_out_item;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [WORD_W-1:0] pwdata      = '0;
    logic [WORD_W-1:0] prdata;
    logic              pready;

    // shadow of the register map, as the block should hold it
    logic [WORD_W-1:0] shadow_delta = DELTA_RESET;
    logic [WORD_W-1:0] shadow_key [NUM_KEYS] = '{default: '0};

    // plaintext blocks still owed by the block, oldest first
    t_out_item   pending_plain [$];

    bit          tx_jitter;
    bit          rx_jitter;
    int unsigned fail_count;
    int unsigned stall_wait;
    int unsigned hold_left;
    int unsigned hold_off_requests;
    int unsigned hold_off_served;

    xtea_block_decipher #(
        .ROUNDS(ROUND_COUNT)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic logic [WORD_W-1:0] mix_word(input logic [WORD_W-1:0] v);
        return v + ((v >> 5) ^ (v << 4));
    endfunction

    // Run the decipher rounds against the shadow key and constant.
    // The sum starts at minus ROUNDS times the constant and wraps freely.
    function automatic t_out_item decipher_block(input t_in_item blk);
        logic [WORD_W-1:0] left;
        logic [WORD_W-1:0] right;
        logic [WORD_W-1:0] sum;
        t_out_item         plain;
        left  = blk.cipher_left;
        right = blk.cipher_right;
        sum   = shadow_delta * ROUND_COUNT;
        sum   = -sum;
        for (int r = 0; r < ROUND_COUNT; r++) begin
            right = right - ((shadow_key[sum[12:11]] + sum) ^ mix_word(left));
            sum   = sum + shadow_delta;
            left  = left - ((shadow_key[sum[1:0]] + sum) ^ mix_word(right));
        end
        plain.plain_left  = left;
        plain.plain_right = right;
        return plain;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Bias random words toward all-zero, all-one and one-hot values.
    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return {{(WORD_W-1){1'b0}}, 1'b1} << $urandom_range(0, WORD_W - 1);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_item corner_block(input int unsigned sel);
        case (sel)
            0:       return {32'h0000_0000, 32'h0000_0000};
            1:       return {32'hFFFF_FFFF, 32'hFFFF_FFFF};
            2:       return {32'h0000_0000, 32'hFFFF_FFFF};
            3:       return {32'hFFFF_FFFF, 32'h0000_0000};
            4:       return {32'h8000_0000, 32'h0000_0001};
            5:       return {32'h0000_0001, 32'h8000_0000};
            6:       return {32'hAAAA_AAAA, 32'h5555_5555};
            default: return {32'h5555_5555, 32'hAAAA_AAAA};
        endcase
    endfunction

    // APB write: setup cycle, then access cycle; the register updates at the
    // edge that closes the access. Mirror the write into the shadow map.
    task automatic write_config_reg(input logic [2:0] idx, input logic [WORD_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_ROUND_CONSTANT: shadow_delta  = value;
            REG_KEY_WORD_0:     shadow_key[0] = value;
            REG_KEY_WORD_1:     shadow_key[1] = value;
            REG_KEY_WORD_2:     shadow_key[2] = value;
            REG_KEY_WORD_3:     shadow_key[3] = value;
            default: ;
        endcase
    endtask

    // Read back every mapped register and compare with the shadow map.
    task automatic verify_registers();
        logic [2:0]        idx;
        logic [WORD_W-1:0] want;
        for (idx = REG_ROUND_CONSTANT; idx <= REG_KEY_WORD_3; idx++) begin
            case (idx)
                REG_ROUND_CONSTANT: want = shadow_delta;
                REG_KEY_WORD_0:     want = shadow_key[0];
                REG_KEY_WORD_1:     want = shadow_key[1];
                REG_KEY_WORD_2:     want = shadow_key[2];
                default:            want = shadow_key[3];
            endcase
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= {idx, 2'b00};
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            if (prdata !== want) begin
                $error("register %0d readback: expected %h, actual %h", idx, want, prdata);
                fail_count++;
            end
            psel    <= 1'b0;
            penable <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic set_config(input logic [WORD_W-1:0] delta,
                              input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
                              input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3);
        write_config_reg(REG_ROUND_CONSTANT, delta);
        write_config_reg(REG_KEY_WORD_0, k0);
        write_config_reg(REG_KEY_WORD_1, k1);
        write_config_reg(REG_KEY_WORD_2, k2);
        write_config_reg(REG_KEY_WORD_3, k3);
        verify_registers();
    endtask

    // Offer one block and hold it until the block takes the transaction.
    // With no gap, leave valid high and just swap the payload so that
    // back-to-back transactions are possible.
    task automatic send_block(input t_in_item blk);
        int unsigned gap;
        gap = tx_jitter ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= blk;
        do @(posedge i_clk); while (o_in_stall);
        pending_plain.push_back(decipher_block(blk));
    endtask

    // Drop valid and wait for every owed result; the pipeline is empty after.
    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_plain.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result checking and receiver stalls
    // ------------------------------------------------------------------

    // Compare each accepted result with the oldest owed block. The same process
    // drives the output stall: a random wait per result while jitter is on,
    // and a long hold-off stretch whenever one is requested.
    always @(posedge i_clk) begin : plain_check
        t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_plain.size() == 0) begin
                    $error("unexpected result: plain_left %h, plain_right %h",
                           o_out_item.plain_left, o_out_item.plain_right);
                    fail_count++;
                end else begin
                    want = pending_plain.pop_front();
                    if (o_out_item.plain_left !== want.plain_left) begin
                        $error("plain_left: expected %h, actual %h",
                               want.plain_left, o_out_item.plain_left);
                        fail_count++;
                    end
                    if (o_out_item.plain_right !== want.plain_right) begin
                        $error("plain_right: expected %h, actual %h",
                               want.plain_right, o_out_item.plain_right);
                        fail_count++;
                    end
                end
                stall_wait = rx_jitter ? $urandom_range(0, MAX_IDLE) : 0;
            end
            if (hold_off_served != hold_off_requests) begin
                hold_left = HOLD_OFF_CYCLES;
                hold_off_served++;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (stall_wait != 0) begin
                stall_wait--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values of the map, then corner blocks under the reset key.
    task automatic test_reset_defaults();
        tx_jitter = 1'b0;
        rx_jitter = 1'b0;
        verify_registers();
        for (int unsigned i = 0; i < 8; i++) send_block(corner_block(i));
        drain_pipeline();
    endtask

    // Zero constant (the sum never moves), all-ones constant and key, and
    // writes past the register map that must change nothing.
    task automatic test_config_extremes();
        tx_jitter = 1'b1;
        rx_jitter = 1'b1;
        set_config('0, $urandom, $urandom, $urandom, $urandom);
        send_block(corner_block(0));
        send_block(corner_block(1));
        send_block(corner_block(6));
        drain_pipeline();

        set_config('1, '1, '1, '1, '1);
        send_block(corner_block(1));
        send_block(corner_block(2));
        send_block(corner_block(3));
        drain_pipeline();

        set_config($urandom, $urandom, $urandom, $urandom, $urandom);
        for (logic [2:0] idx = REG_FIRST_UNMAPPED; idx != REG_ROUND_CONSTANT; idx++)
            write_config_reg(idx, $urandom);
        verify_registers();
        send_block(corner_block(4));
        send_block(corner_block(5));
        drain_pipeline();
    endtask

    // Random blocks across several settings, with idling switched per phase
    // so that some phases run flat out on both sides.
    task automatic test_random_blocks();
        for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: set_config($urandom, $urandom, $urandom, $urandom, $urandom);
                1: set_config(DELTA_RESET, $urandom, $urandom, $urandom, $urandom);
                2: set_config('0, random_word(), random_word(), random_word(), random_word());
                3: set_config('1, '1, '1, '1, '1);
                4: set_config('0, '0, '0, '0, '0);
                default: set_config(32'h8000_0000, $urandom, $urandom, $urandom, $urandom);
            endcase
            tx_jitter = phase[0];
            rx_jitter = phase[1] | (phase >= 4 && $urandom_range(0, 1) != 0);
            repeat (BLOCKS_PER_PHASE) send_block({random_word(), random_word()});
            drain_pipeline();
        end
    endtask

    // Hold the output off for a long stretch while blocks keep coming with no
    // gaps, so that the pipeline fills and must stall its input.
    task automatic test_backpressure();
        tx_jitter = 1'b0;
        rx_jitter = 1'b0;
        set_config($urandom, $urandom, $urandom, $urandom, $urandom);
        hold_off_requests++;
        repeat (BURST_BLOCKS) send_block({random_word(), random_word()});
        drain_pipeline();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_config_extremes();
        test_random_blocks();
        test_backpressure();
        // let any stray result surface before the verdict
        repeat (PIPE_LATENCY + 8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* sim.f */
src/xbd_pkg.sv
src/xbd_cfg.sv
src/xbd_round.sv
src/xtea_block_decipher.sv
tb/xtea_block_decipher_tb.sv
